// ===== sv/utf8v_pkg.sv =====
package utf8v_pkg;

   localparam int POSITION_BITS_DEFAULT = 16;
   localparam int RSP_POSITION_BITS = 16;

   localparam logic [1:0] VERDICT_ASCII   = 2'd0;
   localparam logic [1:0] VERDICT_VALID   = 2'd1;
   localparam logic [1:0] VERDICT_INVALID = 2'd2;

   typedef struct packed {
      logic [1:0]                   verdict;
      logic [RSP_POSITION_BITS-1:0] position;
      logic                         count_overflow;
   } rsp_type;

   // sequence length announced by a lead byte, zero for a bad lead
   function automatic logic [2:0] lead_length(input logic [7:0] b);
      logic [2:0] n;
      n = 3'd0;
      if (b inside {[8'h00:8'h7F]}) begin
         n = 3'd1;
      end else if (b inside {[8'hC2:8'hDF]}) begin
         n = 3'd2;
      end else if (b inside {[8'hE0:8'hEF]}) begin
         n = 3'd3;
      end else if (b inside {[8'hF0:8'hF4]}) begin
         n = 3'd4;
      end
      return n;
   endfunction

   // full check of a completed multi-byte sequence, bytes right aligned
   function automatic logic seq_ok(input logic [2:0] len, input logic [31:0] v);
      logic ok;
      ok = 1'b0;
      case (len)
         3'd2: begin
            ok = (v[7:0] & 8'hC0) == 8'h80;
         end
         3'd3: begin
            ok = ((v & 32'h00F0C0C0) == 32'h00E08080)
               && (v >= 32'h00E0A080)
               && ((v & 32'h00EFA080) != 32'h00EDA080)
               && !((v >= 32'h00EFB790) && ((v <= 32'h00EFB7AF) || (v >= 32'h00EFBFBE)));
         end
         3'd4: begin
            ok = ((v & 32'hF8C0C0C0) == 32'hF0808080)
               && (v >= 32'hF0908080)
               && (v <= 32'hF48FBFBF)
               && ((v & 32'h000FBFBE) != 32'h000FBFBE);
         end
         default: begin
            ok = 1'b0;
         end
      endcase
      return ok;
   endfunction

endpackage

// ===== sv/utf8_stream_validator.sv =====
// a final beat passes through the input register, then its result is held in the result register
// throughput: one byte beat per cycle; non-final beats keep flowing while a result waits
// the input register only holds when a final beat meets a stalled full result register
// reset: synchronous, active high; clears both registers' valid flags and the scan state
module utf8_stream_validator #(
   parameter int POSITION_BITS = utf8v_pkg::POSITION_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_verdict,
   output logic [15:0] rsp_position,
   output logic        rsp_count_overflow
);

   logic               in_valid_ff, in_valid_in;
   logic [7:0]         in_byte_ff;
   logic               in_last_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   utf8v_pkg::rsp_type rsp_ff;
   utf8v_pkg::rsp_type result;
   logic               advance;
   logic               req_take;

   assign advance   = in_valid_ff && (!in_last_ff || !rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   utf8v_scan #(
      .POSITION_BITS(POSITION_BITS)
   ) u_scan (
      .clock    (clock),
      .reset    (reset),
      .step     (advance),
      .data_byte(in_byte_ff),
      .last_byte(in_last_ff),
      .result   (result)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (advance && in_last_ff) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_data_byte;
         in_last_ff <= req_last_byte;
      end
      if (advance && in_last_ff) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_verdict        = rsp_ff.verdict;
   assign rsp_position       = rsp_ff.position;
   assign rsp_count_overflow = rsp_ff.count_overflow;

`ifndef SYNTHESIS
   // only a held final beat can back-pressure the input
   a_stall_needs_final: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && in_last_ff && rsp_valid_ff))
      else $error("input stalled without a blocked final beat");

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid_ff && rsp_valid_in) |-> (advance && in_last_ff))
      else $error("result raised without a final beat");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !in_valid_ff))
      else $error("valid flags not cleared by reset");
`endif

endmodule

// ===== sv/utf8v_scan.sv =====
module utf8v_scan #(
   parameter int POSITION_BITS = utf8v_pkg::POSITION_BITS_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               step,
   input  logic [7:0]         data_byte,
   input  logic               last_byte,
   output utf8v_pkg::rsp_type result
);

   localparam logic [POSITION_BITS-1:0] COUNT_MAX = '1;

   logic [POSITION_BITS-1:0] byte_count_ff, byte_count_in;
   logic [POSITION_BITS-1:0] seq_start_ff, seq_start_in;
   logic [23:0]              seq_bytes_ff, seq_bytes_in;
   logic [2:0]               seq_length_ff, seq_length_in;
   logic [1:0]               pending_ff, pending_in;
   logic                     ascii_ff, ascii_in;
   logic                     failed_ff, failed_in;
   logic [POSITION_BITS-1:0] fail_offset_ff, fail_offset_in;
   logic                     overflowed_ff, overflowed_in;

   logic [POSITION_BITS-1:0] count_next;
   logic                     ovf_next;
   logic [POSITION_BITS-1:0] start_next;
   logic [23:0]              bytes_next;
   logic [2:0]               length_next;
   logic [1:0]               pend_next;
   logic                     ascii_next;
   logic                     failed_next;
   logic [POSITION_BITS-1:0] offset_next;
   logic [2:0]               lead_n;
   logic [31:0]              seq_word;
   logic [POSITION_BITS-1:0] pos_sel;
   logic [31:0]              pos_wide;

   assign lead_n   = utf8v_pkg::lead_length(data_byte);
   assign seq_word = {seq_bytes_ff, data_byte};

   always_comb begin
      count_next  = (byte_count_ff == COUNT_MAX) ? byte_count_ff : byte_count_ff + 1'b1;
      ovf_next    = overflowed_ff | (byte_count_ff == COUNT_MAX);
      start_next  = seq_start_ff;
      bytes_next  = seq_bytes_ff;
      length_next = seq_length_ff;
      pend_next   = pending_ff;
      ascii_next  = ascii_ff;
      failed_next = failed_ff;
      offset_next = fail_offset_ff;

      if (!failed_ff) begin
         if (pending_ff == 2'd0) begin
            if (lead_n == 3'd0) begin
               failed_next = 1'b1;
               offset_next = byte_count_ff;
            end else if (lead_n > 3'd1) begin
               start_next  = byte_count_ff;
               bytes_next  = {16'd0, data_byte};
               length_next = lead_n;
               pend_next   = 2'(lead_n - 3'd1);
            end
         end else begin
            pend_next = pending_ff - 2'd1;
            if (pending_ff == 2'd1) begin
               if (utf8v_pkg::seq_ok(seq_length_ff, seq_word)) begin
                  ascii_next = 1'b0;
               end else begin
                  failed_next = 1'b1;
                  offset_next = seq_start_ff;
               end
               bytes_next  = 24'd0;
               length_next = 3'd0;
            end else begin
               bytes_next = seq_word[23:0];
            end
         end
      end

      // sequence cut off by the end of the buffer
      if (last_byte && !failed_next && (pend_next != 2'd0)) begin
         failed_next = 1'b1;
         offset_next = start_next;
      end

      pos_sel  = failed_next ? offset_next : count_next;
      pos_wide = 32'(pos_sel);
      result.verdict = failed_next ? utf8v_pkg::VERDICT_INVALID
                     : (ascii_next ? utf8v_pkg::VERDICT_ASCII : utf8v_pkg::VERDICT_VALID);
      result.position       = pos_wide[utf8v_pkg::RSP_POSITION_BITS-1:0];
      result.count_overflow = ovf_next;

      if (last_byte) begin
         byte_count_in  = '0;
         seq_start_in   = '0;
         seq_bytes_in   = '0;
         seq_length_in  = '0;
         pending_in     = '0;
         ascii_in       = 1'b1;
         failed_in      = 1'b0;
         fail_offset_in = '0;
         overflowed_in  = 1'b0;
      end else begin
         byte_count_in  = count_next;
         seq_start_in   = start_next;
         seq_bytes_in   = bytes_next;
         seq_length_in  = length_next;
         pending_in     = pend_next;
         ascii_in       = ascii_next;
         failed_in      = failed_next;
         fail_offset_in = offset_next;
         overflowed_in  = ovf_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_count_ff  <= '0;
         seq_start_ff   <= '0;
         seq_bytes_ff   <= '0;
         seq_length_ff  <= '0;
         pending_ff     <= '0;
         ascii_ff       <= 1'b1;
         failed_ff      <= 1'b0;
         fail_offset_ff <= '0;
         overflowed_ff  <= 1'b0;
      end else if (step) begin
         byte_count_ff  <= byte_count_in;
         seq_start_ff   <= seq_start_in;
         seq_bytes_ff   <= seq_bytes_in;
         seq_length_ff  <= seq_length_in;
         pending_ff     <= pending_in;
         ascii_ff       <= ascii_in;
         failed_ff      <= failed_in;
         fail_offset_ff <= fail_offset_in;
         overflowed_ff  <= overflowed_in;
      end
   end

`ifndef SYNTHESIS
   // no sequence left open once a failure is latched
   a_fail_closes_seq: assert property (@(posedge clock) disable iff (reset)
      failed_ff |-> (pending_ff == 2'd0))
      else $error("sequence still open after failure");

   a_pending_below_len: assert property (@(posedge clock) disable iff (reset)
      (pending_ff != 2'd0) |-> (seq_length_ff > {1'b0, pending_ff}))
      else $error("pending count not below sequence length");

   a_overflow_saturated: assert property (@(posedge clock) disable iff (reset)
      overflowed_ff |-> (byte_count_ff == COUNT_MAX))
      else $error("overflow flagged with unsaturated count");
`endif

endmodule
